[hdl/chbif_pkg.sv]
package chbif_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int COEF_FRAC    = 15;
    localparam int TAP_COUNT    = 12;
    localparam int PAIR_COUNT   = TAP_COUNT / 2;
    localparam int CENTRE_DEPTH = 6;
    localparam int OUT_W        = 20;
    localparam int CHAN_COUNT   = 2;

    localparam int PAIR_W    = SAMPLE_W + 1;
    localparam int PROD_W    = PAIR_W + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(PAIR_COUNT);
    localparam int PAIR_IDX_W = $clog2(PAIR_COUNT);
    localparam int CFG_IDX_W = PAIR_IDX_W;

    // channel slots in the datapath arrays
    localparam int CH_REAL = 0;
    localparam int CH_IMAG = 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] real_sample;
        logic signed [SAMPLE_W-1:0] imag_sample;
        logic signed [SAMPLE_W-1:0] real_centre_sample;
        logic signed [SAMPLE_W-1:0] imag_centre_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] real_result;
        logic signed [OUT_W-1:0] imag_result;
    } out_item_t;

    typedef struct packed {
        logic                  load;
        logic                  mac_en;
        logic                  acc_en;
        logic [PAIR_IDX_W-1:0] coef_sel;
        logic                  out_load;
    } dp_cmd_t;

endpackage

[hdl/complex_halfband_interpolation_fir_core.sv]
// An accepted item runs through ST_MAC, ST_FLUSH and ST_HOLD; its result is registered in
// the output register once that is free. The six tap pairs share one multiplier per
// channel, one pair per cycle; no new item is taken until the result has been written.
// An item is taken while an earlier result still waits in the output register.
// Reset (rst_n low, asynchronous) clears the delay lines, coefficients and all control state.
module complex_halfband_interpolation_fir_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  chbif_pkg::in_item_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output chbif_pkg::out_item_t             out_data,
    input  logic                             cfg_write,
    input  logic [chbif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chbif_pkg::COEF_W-1:0]     cfg_data
);
    import chbif_pkg::*;

    dp_cmd_t cmd;

    chbif_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    chbif_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

[hdl/chbif_ctrl.sv]
module chbif_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output chbif_pkg::dp_cmd_t cmd
);
    import chbif_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [PAIR_IDX_W-1:0] cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  last_pair;

    assign last_pair = (cnt_reg == PAIR_IDX_W'(PAIR_COUNT - 1));

    always_comb
    begin
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.mac_en   = (state_reg == ST_MAC);
        // product of step k is registered and added to the accumulator in the next step
        cmd.acc_en   = ((state_reg == ST_MAC) && (cnt_reg != '0)) || (state_reg == ST_FLUSH);
        cmd.coef_sel = cnt_reg;
        cmd.out_load = (state_reg == ST_HOLD) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
            end
            ST_MAC:
            begin
                if (last_pair)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (cmd.out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hdl/chbif_datapath.sv]
module chbif_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  chbif_pkg::dp_cmd_t                   cmd,
    input  chbif_pkg::in_item_t                  in_data,
    input  logic                                 cfg_write,
    input  logic [chbif_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chbif_pkg::COEF_W-1:0]         cfg_data,
    output chbif_pkg::out_item_t                 out_data
);
    import chbif_pkg::*;

    logic signed [COEF_W-1:0]   coef_reg  [PAIR_COUNT];
    logic signed [SAMPLE_W-1:0] line_reg  [CHAN_COUNT][TAP_COUNT];
    logic signed [SAMPLE_W-1:0] cdl_reg   [CHAN_COUNT][CENTRE_DEPTH];
    logic signed [SAMPLE_W-1:0] delayed_reg [CHAN_COUNT];
    logic signed [PAIR_W-1:0]   pair_reg  [CHAN_COUNT][PAIR_COUNT];
    logic signed [PROD_W-1:0]   prod_reg  [CHAN_COUNT];
    logic signed [ACC_W-1:0]    acc_reg   [CHAN_COUNT];
    out_item_t                  out_reg;

    logic signed [SAMPLE_W-1:0] new_sample [CHAN_COUNT];
    logic signed [SAMPLE_W-1:0] new_centre [CHAN_COUNT];
    logic signed [SAMPLE_W-1:0] win        [CHAN_COUNT][TAP_COUNT];
    logic signed [PAIR_W-1:0]   pair_next  [CHAN_COUNT][PAIR_COUNT];
    logic signed [COEF_W-1:0]   coef_cur;
    logic signed [ACC_W-1:0]    shifted    [CHAN_COUNT];
    logic signed [ACC_W-1:0]    sum        [CHAN_COUNT];

    assign new_sample[CH_REAL] = in_data.real_sample;
    assign new_sample[CH_IMAG] = in_data.imag_sample;
    assign new_centre[CH_REAL] = in_data.real_centre_sample;
    assign new_centre[CH_IMAG] = in_data.imag_centre_sample;

    assign coef_cur = coef_reg[cmd.coef_sel];

    // window of the accepted item: new sample at tap 0, history behind it
    always_comb
    begin
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            win[c][0] = new_sample[c];
            for (int k = 1; k < TAP_COUNT; k++)
            begin
                win[c][k] = line_reg[c][k-1];
            end
            for (int i = 0; i < PAIR_COUNT; i++)
            begin
                pair_next[c][i] = PAIR_W'(win[c][i]) + PAIR_W'(win[c][TAP_COUNT-1-i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAIR_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_write && (cfg_index < CFG_IDX_W'(PAIR_COUNT)))
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // delay lines hold filter state and are cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHAN_COUNT; c++)
            begin
                for (int k = 0; k < TAP_COUNT; k++)
                begin
                    line_reg[c][k] <= '0;
                end
                for (int k = 0; k < CENTRE_DEPTH; k++)
                begin
                    cdl_reg[c][k] <= '0;
                end
            end
        end
        else if (cmd.load)
        begin
            for (int c = 0; c < CHAN_COUNT; c++)
            begin
                for (int k = 0; k < TAP_COUNT; k++)
                begin
                    line_reg[c][k] <= win[c][k];
                end
                cdl_reg[c][0] <= new_centre[c];
                for (int k = 1; k < CENTRE_DEPTH; k++)
                begin
                    cdl_reg[c][k] <= cdl_reg[c][k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            if (cmd.load)
            begin
                delayed_reg[c] <= cdl_reg[c][CENTRE_DEPTH-1];
                for (int i = 0; i < PAIR_COUNT; i++)
                begin
                    pair_reg[c][i] <= pair_next[c][i];
                end
                acc_reg[c] <= '0;
            end
            else
            begin
                if (cmd.mac_en)
                begin
                    // pair sums move down one slot per step, slot 0 feeds the multiplier
                    for (int i = 0; i < PAIR_COUNT - 1; i++)
                    begin
                        pair_reg[c][i] <= pair_reg[c][i+1];
                    end
                    prod_reg[c] <= pair_reg[c][0] * coef_cur;
                end
                if (cmd.acc_en)
                begin
                    acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c]);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            shifted[c] = acc_reg[c] >>> COEF_FRAC;
            sum[c]     = shifted[c] + ACC_W'(delayed_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.real_result <= sum[CH_REAL][OUT_W-1:0];
            out_reg.imag_result <= sum[CH_IMAG][OUT_W-1:0];
        end
    end

    assign out_data = out_reg;

endmodule

[hdl/chbif_checker.sv]
module chbif_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  chbif_pkg::out_item_t out_data
);
    import chbif_pkg::*;

    // a held result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("held result changed");

    // an accepted item stalls the input side, which is still stalled when the flush step is reached
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##7 in_stall)
        else $error("input released before result was formed");

    // a new result only comes out of an item in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without item in progress");

endmodule

bind complex_halfband_interpolation_fir_core chbif_checker u_chbif_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
